// ----- rtl/ubxr_pkg.sv -----
// ============================================================================
// ubxr_pkg
// Shared codes and constants of the frame payload receiver.
// ============================================================================
package ubxr_pkg;

    typedef logic [1:0] t_kind;
    typedef logic [1:0] t_status;

    localparam t_kind KIND_START = 2'd0;
    localparam t_kind KIND_BYTE  = 2'd1;
    localparam t_kind KIND_TICK  = 2'd2;

    localparam t_status STATUS_BYTE    = 2'd0;
    localparam t_status STATUS_EMPTY   = 2'd1;
    localparam t_status STATUS_TIMEOUT = 2'd2;

    typedef logic [1:0] t_cfg_index;

    localparam t_cfg_index CFG_MSG_CLASS  = 2'd0;
    localparam t_cfg_index CFG_MESSAGE_ID = 2'd1;
    localparam t_cfg_index CFG_DEADLINE   = 2'd2;

    localparam logic [7:0]  SYNC_FIRST     = 8'hB5;
    localparam logic [7:0]  SYNC_SECOND    = 8'h62;
    localparam logic [7:0]  CLASS_RESET    = 8'd1;
    localparam logic [7:0]  MSGID_RESET    = 8'd7;
    localparam logic [23:0] DEADLINE_RESET = 24'd230000;

endpackage

// ----- rtl/ubx_payload_receiver.sv -----
// ============================================================================
// ubx_payload_receiver
// Hunts for one binary GNSS frame in a byte stream and emits its payload, or an empty or timeout result.
// ============================================================================
//
//   channel   direction  handshake            payload
//   input     in         i_valid / o_ready    i_kind, i_rx_byte
//   output    out        o_valid / i_ready    o_status, o_data_byte,
//                                             o_byte_index, o_frame_length, o_last
//   config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// One request per cycle while o_ready is high; a result shows in the cycle after its request is taken.
// The frame state and the result register update in the same cycle.
// o_ready stays high while the result register is empty or being drained.
// A stalled result holds; new requests wait until it leaves.
// Reset is synchronous and disarms the receiver; control and config registers take reset values.
module ubx_payload_receiver
    import ubxr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [7:0]  o_data_byte,
    output logic [15:0] o_byte_index,
    output logic [15:0] o_frame_length,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_SYNC_A  = 3'd1;
    localparam logic [2:0] PH_SYNC_B  = 3'd2;
    localparam logic [2:0] PH_CLASS   = 3'd3;
    localparam logic [2:0] PH_MSGID   = 3'd4;
    localparam logic [2:0] PH_LEN_LO  = 3'd5;
    localparam logic [2:0] PH_LEN_HI  = 3'd6;
    localparam logic [2:0] PH_PAYLOAD = 3'd7;

    logic [7:0]  r_msg_class;
    logic [7:0]  r_message_id;
    logic [23:0] r_deadline;

    logic [2:0]  r_phase,  n_phase;
    logic [15:0] r_length, n_length;
    logic [15:0] r_taken,  n_taken;
    logic [23:0] r_time,   n_time;

    logic        r_out_valid, n_out_valid;
    t_status     r_status,    n_status;
    logic [7:0]  r_data,      n_data;
    logic [15:0] r_index,     n_index;
    logic [15:0] r_flen,      n_flen;
    logic        r_last,      n_last;

    logic        accept;
    logic [15:0] taken_inc;
    logic [15:0] length_full;

    assign o_ready      = !r_out_valid || i_ready;
    assign accept       = i_valid && o_ready;
    assign taken_inc    = r_taken + 16'd1;
    assign length_full  = {i_rx_byte, r_length[7:0]};

    always_comb begin
        n_phase     = r_phase;
        n_length    = r_length;
        n_taken     = r_taken;
        n_time      = r_time;
        n_out_valid = r_out_valid && !i_ready;
        n_status    = r_status;
        n_data      = r_data;
        n_index     = r_index;
        n_flen      = r_flen;
        n_last      = r_last;

        if (accept) begin
            if (i_kind == KIND_START) begin
                n_phase  = PH_SYNC_A;
                n_length = 16'd0;
                n_taken  = 16'd0;
                n_time   = r_deadline;
            end else if (r_phase != PH_IDLE && i_kind == KIND_TICK) begin
                if (r_time != 24'd0) begin
                    n_time = r_time - 24'd1;
                end
                if (r_time <= 24'd1) begin
                    n_phase     = PH_IDLE;
                    n_out_valid = 1'b1;
                    n_status    = STATUS_TIMEOUT;
                    n_data      = 8'd0;
                    n_index     = 16'd0;
                    n_flen      = 16'd0;
                    n_last      = 1'b1;
                end
            end else if (r_phase != PH_IDLE && i_kind == KIND_BYTE) begin
                unique case (r_phase)
                    PH_SYNC_A: begin
                        n_phase = (i_rx_byte == SYNC_FIRST) ? PH_SYNC_B : PH_SYNC_A;
                    end
                    PH_SYNC_B: begin
                        n_phase = (i_rx_byte == SYNC_SECOND) ? PH_CLASS : PH_SYNC_A;
                    end
                    PH_CLASS: begin
                        n_phase = (i_rx_byte == r_msg_class) ? PH_MSGID : PH_SYNC_A;
                    end
                    PH_MSGID: begin
                        n_phase = (i_rx_byte == r_message_id) ? PH_LEN_LO : PH_SYNC_A;
                    end
                    PH_LEN_LO: begin
                        n_length = {8'd0, i_rx_byte};
                        n_phase  = PH_LEN_HI;
                    end
                    PH_LEN_HI: begin
                        n_length = length_full;
                        n_taken  = 16'd0;
                        if (length_full == 16'd0) begin
                            n_phase     = PH_IDLE;
                            n_out_valid = 1'b1;
                            n_status    = STATUS_EMPTY;
                            n_data      = 8'd0;
                            n_index     = 16'd0;
                            n_flen      = 16'd0;
                            n_last      = 1'b1;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD: begin
                        n_taken     = taken_inc;
                        n_out_valid = 1'b1;
                        n_status    = STATUS_BYTE;
                        n_data      = i_rx_byte;
                        n_index     = r_taken;
                        n_flen      = r_length;
                        n_last      = (taken_inc == r_length);
                        if (taken_inc == r_length) begin
                            n_phase = PH_IDLE;
                        end
                    end
                    default: begin
                        n_phase = PH_SYNC_A;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msg_class  <= CLASS_RESET;
            r_message_id <= MSGID_RESET;
            r_deadline   <= DEADLINE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MSG_CLASS:  r_msg_class  <= i_cfg_data[7:0];
                CFG_MESSAGE_ID: r_message_id <= i_cfg_data[7:0];
                CFG_DEADLINE:   r_deadline   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_length    <= 16'd0;
            r_taken     <= 16'd0;
            r_time      <= 24'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_length    <= n_length;
            r_taken     <= n_taken;
            r_time      <= n_time;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_data   <= n_data;
        r_index  <= n_index;
        r_flen   <= n_flen;
        r_last   <= n_last;
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_data_byte    = r_data;
    assign o_byte_index   = r_index;
    assign o_frame_length = r_flen;
    assign o_last         = r_last;

endmodule

// ----- rtl/ubxr_checker.sv -----
// ============================================================================
// ubxr_checker
// Port-level checks of the frame payload receiver.
// ============================================================================
module ubxr_checker
    import ubxr_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_status,
    input logic [7:0]  o_data_byte,
    input logic [15:0] o_byte_index,
    input logic [15:0] o_frame_length,
    input logic        o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(o_valid && !i_ready) |->
            o_valid && $stable(o_status) && $stable(o_data_byte) && $stable(o_last))
        else $error("stalled result changed");

    a_timeout_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == STATUS_TIMEOUT |->
            o_last && o_data_byte == 8'd0 && o_frame_length == 16'd0 && o_byte_index == 16'd0)
        else $error("timeout result malformed");

    a_empty_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == STATUS_EMPTY |->
            o_last && o_frame_length == 16'd0 && o_byte_index == 16'd0)
        else $error("empty frame result malformed");

    a_byte_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == STATUS_BYTE |->
            o_byte_index < o_frame_length
            && o_last == ((o_byte_index + 16'd1) == o_frame_length))
        else $error("payload byte index or last flag wrong");

endmodule

bind ubx_payload_receiver ubxr_checker u_ubxr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_status       (o_status),
    .o_data_byte    (o_data_byte),
    .o_byte_index   (o_byte_index),
    .o_frame_length (o_frame_length),
    .o_last         (o_last)
);

// ----- sim/tb_ubx_payload_receiver.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_ubx_payload_receiver
// Self-checking bench for the frame payload receiver. A scoreboard class
// tracks the frame hunt, header match, length and deadline, and records
// the payload bytes, empty-frame completions and timeouts that each
// accepted request should produce. Every result is compared against
// that record. The stimulus opens with hand-built frames and broken
// headers, then runs mostly well-formed frames with random content,
// mixed with header faults, oversized lengths, tick bursts and noise.
// It changes the match registers and the deadline between phases, and
// applies random gaps and stalls on both channels.
// ============================================================================
module tb_ubx_payload_receiver;
    import ubxr_pkg::*;

    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 9;
    localparam int ITEM_TARGET    = 1850;
    localparam int NUM_PHASES     = 8;
    localparam int SETTLE_CYCLES  = 4;
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam t_kind KIND_UNUSED = 2'd3;

    typedef enum logic [2:0] {
        HUNT_IDLE,
        HUNT_SYNC_A,
        HUNT_SYNC_B,
        HUNT_CLASS,
        HUNT_MSGID,
        HUNT_LEN_LO,
        HUNT_LEN_HI,
        HUNT_PAYLOAD
    } t_hunt;

    typedef struct packed {
        t_status     status;
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
        logic [15:0] frame_length;
        logic        last;
    } t_frame_result;

    class frame_scoreboard;
        logic [7:0]    msg_class;
        logic [7:0]    message_id;
        logic [23:0]   deadline;
        t_hunt         hunt;
        logic [15:0]   length_seen;
        logic [15:0]   bytes_taken;
        logic [23:0]   ticks_left;
        t_frame_result awaited[$];
        int            errors;
        int            useful;

        function new();
            msg_class   = CLASS_RESET;
            message_id  = MSGID_RESET;
            deadline    = DEADLINE_RESET;
            hunt        = HUNT_IDLE;
            length_seen = '0;
            bytes_taken = '0;
            ticks_left  = '0;
            errors      = 0;
            useful      = 0;
        endfunction

        function void set_register(t_cfg_index idx, logic [23:0] value);
            case (idx)
                CFG_MSG_CLASS:  msg_class = value[7:0];
                CFG_MESSAGE_ID: message_id = value[7:0];
                CFG_DEADLINE:   deadline = value;
                default: ;
            endcase
        endfunction

        function void queue_result(t_status status, logic [7:0] data_byte,
                                   logic [15:0] idx, logic [15:0] len, logic fin);
            awaited.push_back('{status, data_byte, idx, len, fin});
        endfunction

        function void note_request(t_kind kind, logic [7:0] rx);
            logic [15:0] next_taken;
            if (kind == KIND_START) begin
                hunt        = HUNT_SYNC_A;
                length_seen = '0;
                bytes_taken = '0;
                ticks_left  = deadline;
                useful++;
                return;
            end
            if (hunt == HUNT_IDLE || (kind != KIND_BYTE && kind != KIND_TICK))
                return;
            useful++;
            if (kind == KIND_TICK) begin
                if (ticks_left != 0)
                    ticks_left = ticks_left - 24'd1;
                if (ticks_left == 0) begin
                    hunt = HUNT_IDLE;
                    queue_result(STATUS_TIMEOUT, 8'd0, 16'd0, 16'd0, 1'b1);
                end
                return;
            end
            case (hunt)
                HUNT_SYNC_A: hunt = (rx == SYNC_FIRST) ? HUNT_SYNC_B : HUNT_SYNC_A;
                HUNT_SYNC_B: hunt = (rx == SYNC_SECOND) ? HUNT_CLASS : HUNT_SYNC_A;
                HUNT_CLASS:  hunt = (rx == msg_class) ? HUNT_MSGID : HUNT_SYNC_A;
                HUNT_MSGID:  hunt = (rx == message_id) ? HUNT_LEN_LO : HUNT_SYNC_A;
                HUNT_LEN_LO: begin
                    length_seen = {8'd0, rx};
                    hunt = HUNT_LEN_HI;
                end
                HUNT_LEN_HI: begin
                    length_seen = {rx, length_seen[7:0]};
                    bytes_taken = '0;
                    if (length_seen == 0) begin
                        hunt = HUNT_IDLE;
                        queue_result(STATUS_EMPTY, 8'd0, 16'd0, 16'd0, 1'b1);
                    end else begin
                        hunt = HUNT_PAYLOAD;
                    end
                end
                HUNT_PAYLOAD: begin
                    next_taken = bytes_taken + 16'd1;
                    queue_result(STATUS_BYTE, rx, bytes_taken, length_seen,
                                 next_taken == length_seen);
                    if (next_taken == length_seen)
                        hunt = HUNT_IDLE;
                    bytes_taken = next_taken;
                end
                default: hunt = HUNT_SYNC_A;
            endcase
        endfunction

        function void check_result(t_frame_result got);
            t_frame_result want;
            if (awaited.size() == 0) begin
                $error("unexpected result: status %0d, data_byte %0h, byte_index %0d",
                       got.status, got.data_byte, got.byte_index);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.status != want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.data_byte != want.data_byte) begin
                $error("data_byte: expected %0h, got %0h", want.data_byte, got.data_byte);
                errors++;
            end
            if (got.byte_index != want.byte_index) begin
                $error("byte_index: expected %0d, got %0d", want.byte_index, got.byte_index);
                errors++;
            end
            if (got.frame_length != want.frame_length) begin
                $error("frame_length: expected %0d, got %0d",
                       want.frame_length, got.frame_length);
                errors++;
            end
            if (got.last != want.last) begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_ready;
    logic [1:0]  i_kind      = KIND_START;
    logic [7:0]  i_rx_byte   = 8'd0;
    logic        o_valid;
    logic        i_ready     = 1'b0;
    logic [1:0]  o_status;
    logic [7:0]  o_data_byte;
    logic [15:0] o_byte_index;
    logic [15:0] o_frame_length;
    logic        o_last;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_index = CFG_MSG_CLASS;
    logic [23:0] i_cfg_data  = 24'd0;

    frame_scoreboard sb;
    int idle_mode    = 0;
    int holds_asked  = 0;
    int holds_done   = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;

    ubx_payload_receiver dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_kind         (i_kind),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_data_byte    (o_data_byte),
        .o_byte_index   (o_byte_index),
        .o_frame_length (o_frame_length),
        .o_last         (o_last),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // receiver: random stalls, or a long hold when asked
    always @(posedge i_clk) begin
        int stall_pct;
        stall_pct = (idle_mode == 0) ? 52 : (idle_mode == 1) ? 10 : 0;
        if (holds_done != holds_asked) begin
            holds_done = holds_asked;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            quiet_cycles++;
            if (o_valid && i_ready) begin
                sb.check_result('{o_status, o_data_byte, o_byte_index,
                                  o_frame_length, o_last});
                quiet_cycles = 0;
            end
            if (i_valid && o_ready) begin
                sb.note_request(i_kind, i_rx_byte);
                quiet_cycles = 0;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic send(input t_kind kind, input logic [7:0] rx);
        int gap_pct;
        int gap;
        gap_pct = (idle_mode == 0) ? 10 : (idle_mode == 1) ? 52 : 0;
        gap = 0;
        while ($urandom_range(0, 99) < gap_pct)
            gap++;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_kind    <= kind;
        i_rx_byte <= rx;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.awaited.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input logic [7:0] cls, input logic [7:0] msg,
                             input logic [23:0] ticks);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_MSG_CLASS;
        i_cfg_data  <= {16'd0, cls};
        @(posedge i_clk);
        sb.set_register(CFG_MSG_CLASS, {16'd0, cls});
        i_cfg_index <= CFG_MESSAGE_ID;
        i_cfg_data  <= {16'd0, msg};
        @(posedge i_clk);
        sb.set_register(CFG_MESSAGE_ID, {16'd0, msg});
        i_cfg_index <= CFG_DEADLINE;
        i_cfg_data  <= ticks;
        @(posedge i_clk);
        sb.set_register(CFG_DEADLINE, ticks);
        i_cfg_we <= 1'b0;
    endtask

    // header with the configured ids, then up to count payload bytes
    task automatic send_frame(input logic [15:0] len, input int count);
        int n;
        send(KIND_BYTE, SYNC_FIRST);
        send(KIND_BYTE, SYNC_SECOND);
        send(KIND_BYTE, sb.msg_class);
        send(KIND_BYTE, sb.message_id);
        send(KIND_BYTE, len[7:0]);
        send(KIND_BYTE, len[15:8]);
        n = (count < int'(len)) ? count : int'(len);
        repeat (n) begin
            if ($urandom_range(0, 99) < 8)
                send(KIND_TICK, 8'($urandom));
            send(KIND_BYTE, 8'($urandom));
        end
    endtask

    task automatic run_episode();
        int pick;
        int pos;
        logic [15:0] len;
        logic [7:0] hdr[4];
        pick = $urandom_range(0, 99);
        if (pick >= 95) begin
            repeat ($urandom_range(1, 8))
                send(t_kind'($urandom_range(0, 3)), 8'($urandom));
            return;
        end
        send(KIND_START, 8'($urandom));
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4))
                send(t_kind'($urandom_range(1, 3)), 8'($urandom));
        len = ($urandom_range(0, 99) < 80) ? 16'($urandom_range(0, 6))
                                           : 16'($urandom_range(7, 40));
        if (pick < 70) begin
            send_frame(len, int'(len));
        end else if (pick < 80) begin
            hdr[0] = SYNC_FIRST;
            hdr[1] = SYNC_SECOND;
            hdr[2] = sb.msg_class;
            hdr[3] = sb.message_id;
            pos = $urandom_range(0, 3);
            hdr[pos] = hdr[pos] ^ 8'($urandom_range(1, 255));
            if (pos == 1 && $urandom_range(0, 1) == 0)
                hdr[1] = SYNC_FIRST;
            for (int k = 0; k <= pos; k++)
                send(KIND_BYTE, hdr[k]);
            send_frame(len, int'(len));
        end else if (pick < 85) begin
            len = ($urandom_range(0, 1) == 0) ? 16'hFFFF : {8'hFF, 8'($urandom)};
            send_frame(len, $urandom_range(1, 5));
        end else begin
            repeat ($urandom_range(1, 6))
                send(KIND_TICK, 8'($urandom));
        end
    endtask

    initial begin
        int target;
        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ignored while disarmed
        send(KIND_TICK, 8'h00);
        send(KIND_BYTE, SYNC_FIRST);
        send(KIND_UNUSED, 8'hFF);
        // two-byte frame at the reset ids
        send(KIND_START, 8'h00);
        send(KIND_BYTE, SYNC_FIRST);
        send(KIND_BYTE, SYNC_SECOND);
        send(KIND_BYTE, CLASS_RESET);
        send(KIND_BYTE, MSGID_RESET);
        send(KIND_BYTE, 8'h02);
        send(KIND_BYTE, 8'h00);
        send(KIND_BYTE, 8'h00);
        send(KIND_BYTE, 8'hFF);
        // repeated first sync byte, then a wrong message id
        send(KIND_START, 8'hFF);
        send(KIND_BYTE, SYNC_FIRST);
        send(KIND_BYTE, SYNC_FIRST);
        send(KIND_BYTE, SYNC_SECOND);
        send(KIND_BYTE, SYNC_FIRST);
        send(KIND_BYTE, SYNC_SECOND);
        send(KIND_BYTE, CLASS_RESET);
        send(KIND_BYTE, MSGID_RESET + 8'd1);
        // restart while armed, then an empty frame
        send(KIND_START, 8'h5A);
        send(KIND_UNUSED, 8'h00);
        send(KIND_TICK, 8'hA5);
        send(KIND_BYTE, SYNC_FIRST);
        send(KIND_BYTE, SYNC_SECOND);
        send(KIND_BYTE, CLASS_RESET);
        send(KIND_BYTE, MSGID_RESET);
        send(KIND_BYTE, 8'h00);
        send(KIND_BYTE, 8'h00);

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            case (p)
                0: configure(8'd0, 8'd0, 24'd0);
                1: configure(8'hFF, 8'hFF, 24'hFFFFFF);
                2: configure(8'($urandom), 8'($urandom), 24'($urandom_range(1, 12)));
                default: begin
                    case ($urandom_range(0, 2))
                        0: configure(8'($urandom), 8'($urandom), 24'd1);
                        1: configure(8'($urandom), 8'($urandom),
                                     24'($urandom_range(2, 40)));
                        default: configure(8'($urandom), 8'($urandom), DEADLINE_RESET);
                    endcase
                end
            endcase
            if (p == 3) begin
                // hold the output while a long payload streams in
                holds_asked++;
                send(KIND_START, 8'h00);
                send_frame(16'd30, 30);
            end
            target = ITEM_TARGET * (p + 1) / NUM_PHASES;
            while (sb.useful < target) begin
                idle_mode = (sb.useful * 3) / ITEM_TARGET;
                if (idle_mode > 2)
                    idle_mode = 2;
                run_episode();
            end
        end

        drain_results();
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- ubx_payload_receiver.f -----
rtl/ubxr_pkg.sv
rtl/ubx_payload_receiver.sv
rtl/ubxr_checker.sv
sim/tb_ubx_payload_receiver.sv
